// ===== hdl/ffbp_pkg.sv =====
// shared codes, widths and types for the two-dimensional first-fit bin packer
package ffbp_pkg;

  // field widths
  localparam int AMT_W    = 16;
  localparam int ENTRY_W  = 2 * AMT_W;
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int BIN_W    = 6;
  localparam int OPEN_W   = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_EXISTING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

  // one table entry: volume in the upper half, weight in the lower half
  typedef struct packed {
    logic [AMT_W-1:0] vol;
    logic [AMT_W-1:0] wgt;
  } room_t;

endpackage

// ===== hdl/ffbp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module ffbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/first_fit_two_dim_bin_packer.sv =====
// top level of the two-dimensional first-fit bin packer
//
//  channel  handshake            payload
//  in       in_valid / in_stall  operation, slot_index, volume_amount, weight_amount
//  out      out_valid / out_stall status, bin_index, bins_open
//
// a load, clear or unused code goes from idle to done, then into the output register. a
// place landing in open bin j scans bins 0 to j in check, then done; one opening a new bin
// scans every open bin, then passes new and done; one finding no slot scans them all, then
// done: the scan reads one free-room entry per cycle from the single read port of the
// free-room ram. rst clears the fsm, the open-bin count and the output valid; ram contents
// are undefined until written. the input is taken again in the cycle after the result
// loads; a result held by out_stall keeps the next result, and so the input, waiting.
module first_fit_two_dim_bin_packer #(
  parameter int MAX_BINS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffbp_pkg::OP_W-1:0]     operation,
  input  logic [ffbp_pkg::SLOT_W-1:0]   slot_index,
  input  logic [ffbp_pkg::AMT_W-1:0]    volume_amount,
  input  logic [ffbp_pkg::AMT_W-1:0]    weight_amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffbp_pkg::STATUS_W-1:0] status,
  output logic [ffbp_pkg::BIN_W-1:0]    bin_index,
  output logic [ffbp_pkg::OPEN_W-1:0]   bins_open
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_NEW   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]             open_count;
  logic [IDX_W-1:0]             scan;
  logic [ffbp_pkg::AMT_W-1:0]   item_vol;
  logic [ffbp_pkg::AMT_W-1:0]   item_wgt;
  logic [ffbp_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]             res_bin;

  logic                         in_accept;
  logic [CNT_W-1:0]             scan_next;
  logic                         fits;
  logic                         vol_short;
  logic                         wgt_short;
  logic [IDX_W-1:0]             new_bin;

  logic                         free_wr_en;
  logic [IDX_W-1:0]             free_wr_addr;
  ffbp_pkg::room_t              free_wr_data;
  logic                         free_rd_en;
  logic [IDX_W-1:0]             free_rd_addr;
  ffbp_pkg::room_t              free_rd_data;

  logic                         cap_wr_en;
  logic                         cap_rd_en;
  ffbp_pkg::room_t              cap_wr_data;
  ffbp_pkg::room_t              cap_rd_data;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // scan and new-bin arithmetic
  assign scan_next = CNT_W'(scan) + CNT_W'(1);
  assign fits      = (free_rd_data.vol >= item_vol) && (free_rd_data.wgt >= item_wgt);
  assign vol_short = (cap_rd_data.vol < item_vol);
  assign wgt_short = (cap_rd_data.wgt < item_wgt);
  assign new_bin   = IDX_W'(open_count);

  // ram control
  always_comb begin
    free_wr_en   = 1'b0;
    free_wr_addr = scan;
    free_wr_data = '0;
    free_rd_en   = 1'b0;
    free_rd_addr = '0;
    case (state)
      S_IDLE: begin
        free_rd_en = in_accept && (operation == ffbp_pkg::OP_PLACE);
      end
      S_CHECK: begin
        if (fits) begin
          free_wr_en       = 1'b1;
          free_wr_data.vol = free_rd_data.vol - item_vol;
          free_wr_data.wgt = free_rd_data.wgt - item_wgt;
        end else begin
          free_rd_en   = 1'b1;
          free_rd_addr = IDX_W'(scan_next);
        end
      end
      S_NEW: begin
        free_wr_en       = 1'b1;
        free_wr_addr     = new_bin;
        free_wr_data.vol = vol_short ? '0 : cap_rd_data.vol - item_vol;
        free_wr_data.wgt = wgt_short ? '0 : cap_rd_data.wgt - item_wgt;
      end
      default: begin
        free_wr_en = 1'b0;
      end
    endcase
  end

  assign cap_wr_en   = in_accept && (operation == ffbp_pkg::OP_LOAD) &&
                       (32'(slot_index) < 32'(MAX_BINS));
  assign cap_rd_en   = in_accept && (operation == ffbp_pkg::OP_PLACE);
  assign cap_wr_data = '{vol: volume_amount, wgt: weight_amount};

  // free room of each open bin
  ffbp_ram #(
    .WIDTH (ffbp_pkg::ENTRY_W),
    .DEPTH (MAX_BINS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (free_wr_en),
    .wr_addr (free_wr_addr),
    .wr_data (free_wr_data),
    .rd_en   (free_rd_en),
    .rd_addr (free_rd_addr),
    .rd_data (free_rd_data)
  );

  // capacity of each bin slot
  ffbp_ram #(
    .WIDTH (ffbp_pkg::ENTRY_W),
    .DEPTH (MAX_BINS)
  ) u_cap_ram (
    .clk     (clk),
    .wr_en   (cap_wr_en),
    .wr_addr (IDX_W'(slot_index)),
    .wr_data (cap_wr_data),
    .rd_en   (cap_rd_en),
    .rd_addr (new_bin),
    .rd_data (cap_rd_data)
  );

  // sequencer and open-bin count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            item_vol   <= volume_amount;
            item_wgt   <= weight_amount;
            scan       <= '0;
            res_status <= ffbp_pkg::ST_DONE;
            res_bin    <= '0;
            if (operation == ffbp_pkg::OP_PLACE) begin
              state <= (open_count == '0) ? S_NEW : S_CHECK;
            end else begin
              state <= S_DONE;
              if (operation == ffbp_pkg::OP_CLEAR) begin
                open_count <= '0;
              end
            end
          end
        end
        S_CHECK: begin
          if (fits) begin
            res_status <= ffbp_pkg::ST_EXISTING;
            res_bin    <= scan;
            state      <= S_DONE;
          end else if (scan_next == open_count) begin
            if (32'(open_count) >= 32'(MAX_BINS)) begin
              res_status <= ffbp_pkg::ST_NO_SLOT;
              res_bin    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_NEW;
            end
          end else begin
            scan <= IDX_W'(scan_next);
          end
        end
        S_NEW: begin
          res_status <= (vol_short || wgt_short) ? ffbp_pkg::ST_OVERFULL : ffbp_pkg::ST_NEW;
          res_bin    <= new_bin;
          open_count <= open_count + CNT_W'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status    <= res_status;
      bin_index <= ffbp_pkg::BIN_W'(res_bin);
      bins_open <= ffbp_pkg::OPEN_W'(open_count);
    end
  end

`ifndef SYNTHESIS
  // open-bin count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) 32'(open_count) <= 32'(MAX_BINS))
    else $error("open bin count beyond table depth");

  // the scan only ever looks at open bins
  assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> CNT_W'(scan) < open_count)
    else $error("scan index outside the open bins");

  // one transaction at a time: the input stalls right after a transaction
  assert property (@(posedge clk) disable iff (rst) in_accept |=> in_stall)
    else $error("input not stalled after a transaction");

  // a new bin always grows the count by one
  assert property (@(posedge clk) disable iff (rst)
    state == S_NEW |=> open_count == $past(open_count) + CNT_W'(1))
    else $error("new bin did not advance the open count");
`endif

endmodule
